>>> sv/dcsp_pkg.sv
`timescale 1ns / 1ps

package dcsp_pkg;

   // segment geometry and counter sizing
   localparam int SEGMENT_PIXELS = 6;
   localparam int MAX_ORDER      = 20;
   localparam int COORD_BITS     = 24;

   localparam int IDX_BITS   = MAX_ORDER + 1;
   localparam int T_BITS     = (SEGMENT_PIXELS > 1) ? $clog2(SEGMENT_PIXELS) : 1;
   localparam int PIX_BITS   = 12;
   localparam int ORDER_BITS = 5;
   localparam int HEAD_BITS  = 2;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 12;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // headings
   localparam logic [HEAD_BITS-1:0] HEAD_UP    = 2'd0;
   localparam logic [HEAD_BITS-1:0] HEAD_RIGHT = 2'd1;
   localparam logic [HEAD_BITS-1:0] HEAD_DOWN  = 2'd2;
   localparam logic [HEAD_BITS-1:0] HEAD_LEFT  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_CURVE_ORDER   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_HEADING = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_X       = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_Y       = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT  = 3'd5;

   // register reset values
   localparam logic [ORDER_BITS-1:0] RST_CURVE_ORDER   = 5'd10;
   localparam logic [HEAD_BITS-1:0]  RST_START_HEADING = HEAD_UP;
   localparam logic [PIX_BITS-1:0]   RST_START_X       = 12'd960;
   localparam logic [PIX_BITS-1:0]   RST_START_Y       = 12'd540;
   localparam logic [PIX_BITS-1:0]   RST_IMAGE_WIDTH   = 12'd1920;
   localparam logic [PIX_BITS-1:0]   RST_IMAGE_HEIGHT  = 12'd1080;

   typedef struct packed {
      logic [ORDER_BITS-1:0] curve_order;
      logic [HEAD_BITS-1:0]  start_heading;
      logic [PIX_BITS-1:0]   start_x;
      logic [PIX_BITS-1:0]   start_y;
      logic [PIX_BITS-1:0]   image_width;
      logic [PIX_BITS-1:0]   image_height;
   } cfg_type;

   // one segment to draw, or a done marker
   typedef struct packed {
      logic                         done;
      logic [HEAD_BITS-1:0]         heading;
      logic signed [COORD_BITS-1:0] pen_x;
      logic signed [COORD_BITS-1:0] pen_y;
   } cmd_type;

   // saturate a one-bit-wider sum to the signed coordinate range
   function automatic logic signed [COORD_BITS-1:0] clamp_coord(
      input logic signed [COORD_BITS:0] v);
      logic signed [COORD_BITS-1:0] r;
      if (v[COORD_BITS] != v[COORD_BITS-1]) begin
         r = v[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                           : {1'b0, {(COORD_BITS-1){1'b1}}};
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   // zero-extend a pixel-sized value to a signed coordinate
   function automatic logic signed [COORD_BITS-1:0] pix_to_coord(
      input logic [PIX_BITS-1:0] v);
      return $signed({{(COORD_BITS-PIX_BITS){1'b0}}, v});
   endfunction

endpackage

>>> sv/dcsp_front.sv
`timescale 1ns / 1ps

module dcsp_front (
   input  logic               clock,
   input  logic               reset,
   input  dcsp_pkg::cfg_type  cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_restart,
   input  logic               queue_full,
   output logic               push,
   output dcsp_pkg::cmd_type  push_cmd
);

   logic [dcsp_pkg::IDX_BITS-1:0]          idx_ff, idx_in;
   logic [dcsp_pkg::HEAD_BITS-1:0]         head_ff, head_in;
   logic signed [dcsp_pkg::COORD_BITS-1:0] pen_x_ff, pen_x_in;
   logic signed [dcsp_pkg::COORD_BITS-1:0] pen_y_ff, pen_y_in;

   logic [dcsp_pkg::IDX_BITS-1:0]          base_idx, low_bit, total;
   logic [dcsp_pkg::HEAD_BITS-1:0]         base_head, new_head;
   logic signed [dcsp_pkg::COORD_BITS-1:0] base_x, base_y;
   logic signed [dcsp_pkg::COORD_BITS:0]   sum_x, sum_y;
   logic signed [dcsp_pkg::COORD_BITS:0]   step;
   logic [dcsp_pkg::ORDER_BITS-1:0]        order_eff;
   logic                                   done, turn_right;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign step      = (dcsp_pkg::COORD_BITS+1)'(dcsp_pkg::SEGMENT_PIXELS);

   // restart reloads the pen before this segment
   always_comb begin
      base_idx  = req_restart ? '0 : idx_ff;
      base_head = req_restart ? cfg.start_heading : head_ff;
      base_x    = req_restart ? dcsp_pkg::pix_to_coord(cfg.start_x) : pen_x_ff;
      base_y    = req_restart ? dcsp_pkg::pix_to_coord(cfg.start_y) : pen_y_ff;
   end

   // curve length check
   always_comb begin
      order_eff = (cfg.curve_order > dcsp_pkg::ORDER_BITS'(dcsp_pkg::MAX_ORDER))
                ? dcsp_pkg::ORDER_BITS'(dcsp_pkg::MAX_ORDER) : cfg.curve_order;
      total = dcsp_pkg::IDX_BITS'(1) << order_eff;
      done  = base_idx >= total;
   end

   // turn: look at the bit just above the lowest set bit
   always_comb begin
      low_bit    = base_idx & (~base_idx + dcsp_pkg::IDX_BITS'(1));
      turn_right = |((low_bit << 1) & base_idx);
      if (base_idx == '0) begin
         new_head = base_head;
      end else if (turn_right) begin
         new_head = base_head + dcsp_pkg::HEAD_BITS'(1);
      end else begin
         new_head = base_head - dcsp_pkg::HEAD_BITS'(1);
      end
   end

   // pen after the whole segment (left/up increase)
   always_comb begin
      sum_x = {base_x[dcsp_pkg::COORD_BITS-1], base_x};
      sum_y = {base_y[dcsp_pkg::COORD_BITS-1], base_y};
      unique case (new_head)
         dcsp_pkg::HEAD_UP:    sum_y = sum_y + step;
         dcsp_pkg::HEAD_RIGHT: sum_x = sum_x - step;
         dcsp_pkg::HEAD_DOWN:  sum_y = sum_y - step;
         default:              sum_x = sum_x + step;
      endcase
   end

   assign push_cmd = '{done: done, heading: new_head, pen_x: base_x, pen_y: base_y};

   // state update on an accepted word
   always_comb begin
      idx_in   = idx_ff;
      head_in  = head_ff;
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      if (push) begin
         if (done) begin
            idx_in   = base_idx;
            head_in  = base_head;
            pen_x_in = base_x;
            pen_y_in = base_y;
         end else begin
            idx_in   = base_idx + dcsp_pkg::IDX_BITS'(1);
            head_in  = new_head;
            pen_x_in = dcsp_pkg::clamp_coord(sum_x);
            pen_y_in = dcsp_pkg::clamp_coord(sum_y);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         head_ff  <= dcsp_pkg::RST_START_HEADING;
         pen_x_ff <= dcsp_pkg::pix_to_coord(dcsp_pkg::RST_START_X);
         pen_y_ff <= dcsp_pkg::pix_to_coord(dcsp_pkg::RST_START_Y);
      end else begin
         idx_ff   <= idx_in;
         head_ff  <= head_in;
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
      end
   end

endmodule

>>> sv/dcsp_queue.sv
`timescale 1ns / 1ps

module dcsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dcsp_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output dcsp_pkg::cmd_type  head_cmd
);

   dcsp_pkg::cmd_type                entry_ff [dcsp_pkg::QUEUE_DEPTH];
   logic [dcsp_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dcsp_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dcsp_pkg::QCNT_BITS-1:0]   count_ff, count_in;

   localparam logic [dcsp_pkg::QPTR_BITS-1:0] LAST_PTR =
      dcsp_pkg::QPTR_BITS'(dcsp_pkg::QUEUE_DEPTH - 1);

   assign full       = count_ff == dcsp_pkg::QCNT_BITS'(dcsp_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + dcsp_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + dcsp_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + dcsp_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - dcsp_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> sv/dcsp_back.sv
`timescale 1ns / 1ps

module dcsp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  dcsp_pkg::cfg_type              cfg,
   input  logic                           head_valid,
   input  dcsp_pkg::cmd_type              head_cmd,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dcsp_pkg::PIX_BITS-1:0]  rsp_pixel_x,
   output logic [dcsp_pkg::PIX_BITS-1:0]  rsp_pixel_y,
   output logic                           rsp_on_image,
   output logic                           rsp_last,
   output logic                           rsp_done_res
);

   localparam logic [dcsp_pkg::T_BITS-1:0] LAST_T =
      dcsp_pkg::T_BITS'(dcsp_pkg::SEGMENT_PIXELS - 1);

   logic [dcsp_pkg::T_BITS-1:0]            t_ff, t_in;
   logic                                   valid_ff, valid_in;
   logic [dcsp_pkg::PIX_BITS-1:0]          px_ff, py_ff;
   logic                                   on_ff, last_ff, done_ff;

   logic                                   load, seg_end, on;
   logic signed [dcsp_pkg::COORD_BITS:0]   sum_x, sum_y, offs;
   logic signed [dcsp_pkg::COORD_BITS-1:0] px, py;

   assign load    = head_valid && (!valid_ff || rsp_ready);
   assign seg_end = head_cmd.done || (t_ff == LAST_T);
   assign pop     = load && seg_end;
   assign offs    = $signed({{(dcsp_pkg::COORD_BITS+1-dcsp_pkg::T_BITS){1'b0}}, t_ff});

   // pixel t steps along the heading
   always_comb begin
      sum_x = {head_cmd.pen_x[dcsp_pkg::COORD_BITS-1], head_cmd.pen_x};
      sum_y = {head_cmd.pen_y[dcsp_pkg::COORD_BITS-1], head_cmd.pen_y};
      unique case (head_cmd.heading)
         dcsp_pkg::HEAD_UP:    sum_y = sum_y + offs;
         dcsp_pkg::HEAD_RIGHT: sum_x = sum_x - offs;
         dcsp_pkg::HEAD_DOWN:  sum_y = sum_y - offs;
         default:              sum_x = sum_x + offs;
      endcase
      px = dcsp_pkg::clamp_coord(sum_x);
      py = dcsp_pkg::clamp_coord(sum_y);
      on = (px > 0) && (py > 0)
        && (px < dcsp_pkg::pix_to_coord(cfg.image_width))
        && (py < dcsp_pkg::pix_to_coord(cfg.image_height))
        && !head_cmd.done;
   end

   // pixel counter and output word valid
   always_comb begin
      t_in     = t_ff;
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         t_in     = seg_end ? '0 : t_ff + dcsp_pkg::T_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         t_ff     <= t_in;
         valid_ff <= valid_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (load) begin
         px_ff   <= on ? px[dcsp_pkg::PIX_BITS-1:0] : '0;
         py_ff   <= on ? py[dcsp_pkg::PIX_BITS-1:0] : '0;
         on_ff   <= on;
         last_ff <= seg_end;
         done_ff <= head_cmd.done;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_pixel_x  = px_ff;
   assign rsp_pixel_y  = py_ff;
   assign rsp_on_image = on_ff;
   assign rsp_last     = last_ff;
   assign rsp_done_res = done_ff;

endmodule

>>> sv/dragon_curve_segment_plotter_top.sv
`timescale 1ns / 1ps
// An accepted word enters the command queue; its result words then leave through the
// back end's output register. A segment word yields six pixel words, a done word one,
// emitted one pixel per cycle unless rsp_ready stalls the back end. A two-entry
// command queue lets the front accept new words while the back end is still drawing.
// Reset: synchronous, active high; registers return to their defaults and the pen,
// heading and segment counter reload from those defaults.

module dragon_curve_segment_plotter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [dcsp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [dcsp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dcsp_pkg::PIX_BITS-1:0]       rsp_pixel_x,
   output logic [dcsp_pkg::PIX_BITS-1:0]       rsp_pixel_y,
   output logic                                rsp_on_image,
   output logic                                rsp_last,
   output logic                                rsp_done_res
);

   dcsp_pkg::cfg_type cfg_ff, cfg_in;
   dcsp_pkg::cmd_type push_cmd, head_cmd;
   logic              push, pop, queue_full, head_valid;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            dcsp_pkg::CSR_CURVE_ORDER:
               cfg_in.curve_order = csr_wdata[dcsp_pkg::ORDER_BITS-1:0];
            dcsp_pkg::CSR_START_HEADING:
               cfg_in.start_heading = csr_wdata[dcsp_pkg::HEAD_BITS-1:0];
            dcsp_pkg::CSR_START_X:      cfg_in.start_x      = csr_wdata;
            dcsp_pkg::CSR_START_Y:      cfg_in.start_y      = csr_wdata;
            dcsp_pkg::CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata;
            dcsp_pkg::CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{curve_order:   dcsp_pkg::RST_CURVE_ORDER,
                     start_heading: dcsp_pkg::RST_START_HEADING,
                     start_x:       dcsp_pkg::RST_START_X,
                     start_y:       dcsp_pkg::RST_START_Y,
                     image_width:   dcsp_pkg::RST_IMAGE_WIDTH,
                     image_height:  dcsp_pkg::RST_IMAGE_HEIGHT};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept words, track the curve, build segment commands
   dcsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   dcsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // back: one pixel word per cycle unless rsp_ready stalls it
   dcsp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pixel_x  (rsp_pixel_x),
      .rsp_pixel_y  (rsp_pixel_y),
      .rsp_on_image (rsp_on_image),
      .rsp_last     (rsp_last),
      .rsp_done_res (rsp_done_res)
   );

endmodule

>>> tb/dragon_curve_segment_plotter_top_tb.sv
`timescale 1ns / 1ps

module dragon_curve_segment_plotter_top_tb;

   // spare register slots past the end of the map; writes must be dropped
   localparam logic [dcsp_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [dcsp_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   localparam int SETTLE_LIMIT = 50000;

   typedef struct packed {
      logic [dcsp_pkg::PIX_BITS-1:0] x;
      logic [dcsp_pkg::PIX_BITS-1:0] y;
      logic                          on_img;
      logic                          last;
      logic                          done;
   } plot_word_type;

   // one row of the directed table: either a register write or an input word
   typedef struct {
      bit                                  is_csr;
      logic [dcsp_pkg::CSR_IDX_BITS-1:0]   idx;
      logic [dcsp_pkg::CSR_DATA_BITS-1:0]  data;
      bit                                  restart;
      bit                                  typed;
      plot_word_type                       word;
   } step_type;

   logic                                  clock;
   logic                                  reset        = 1'b1;
   logic                                  csr_wr_en    = 1'b0;
   logic [dcsp_pkg::CSR_IDX_BITS-1:0]     csr_index    = '0;
   logic [dcsp_pkg::CSR_DATA_BITS-1:0]    csr_wdata    = '0;
   logic                                  req_valid    = 1'b0;
   logic                                  req_ready;
   logic                                  req_restart  = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_ready    = 1'b0;
   logic [dcsp_pkg::PIX_BITS-1:0]         rsp_pixel_x;
   logic [dcsp_pkg::PIX_BITS-1:0]         rsp_pixel_y;
   logic                                  rsp_on_image;
   logic                                  rsp_last;
   logic                                  rsp_done_res;

   dragon_curve_segment_plotter_top dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pixel_x  (rsp_pixel_x),
      .rsp_pixel_y  (rsp_pixel_y),
      .rsp_on_image (rsp_on_image),
      .rsp_last     (rsp_last),
      .rsp_done_res (rsp_done_res)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("dragon_curve_segment_plotter_top_tb: errors");
      $finish;
   end

   // plotter copy: registers and pen state
   logic [dcsp_pkg::ORDER_BITS-1:0]         cur_order;
   logic [dcsp_pkg::HEAD_BITS-1:0]          cur_start_head;
   logic [dcsp_pkg::PIX_BITS-1:0]           cur_start_x;
   logic [dcsp_pkg::PIX_BITS-1:0]           cur_start_y;
   logic [dcsp_pkg::PIX_BITS-1:0]           cur_width;
   logic [dcsp_pkg::PIX_BITS-1:0]           cur_height;
   logic [dcsp_pkg::IDX_BITS-1:0]           seg_idx;
   logic [dcsp_pkg::HEAD_BITS-1:0]          heading;
   logic signed [dcsp_pkg::COORD_BITS-1:0]  pen_x;
   logic signed [dcsp_pkg::COORD_BITS-1:0]  pen_y;

   plot_word_type  pending_plots[$];
   step_type       directed[$];
   plot_word_type  want;
   int             error_count    = 0;
   int             send_idle_pct  = 0;
   int             recv_stall_pct = 0;
   int             hold_tag       = 0;
   int             seen_tag       = 0;
   int             hold_left      = 0;

   function automatic longint sat_coord(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (dcsp_pkg::COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic void load_pen();
      seg_idx = '0;
      heading = cur_start_head;
      pen_x   = dcsp_pkg::COORD_BITS'(cur_start_x);
      pen_y   = dcsp_pkg::COORD_BITS'(cur_start_y);
   endfunction

   function automatic void set_reg(logic [dcsp_pkg::CSR_IDX_BITS-1:0] idx,
                                   logic [dcsp_pkg::CSR_DATA_BITS-1:0] data);
      case (idx)
         dcsp_pkg::CSR_CURVE_ORDER:   cur_order      = data[dcsp_pkg::ORDER_BITS-1:0];
         dcsp_pkg::CSR_START_HEADING: cur_start_head = data[dcsp_pkg::HEAD_BITS-1:0];
         dcsp_pkg::CSR_START_X:       cur_start_x    = data[dcsp_pkg::PIX_BITS-1:0];
         dcsp_pkg::CSR_START_Y:       cur_start_y    = data[dcsp_pkg::PIX_BITS-1:0];
         dcsp_pkg::CSR_IMAGE_WIDTH:   cur_width      = data[dcsp_pkg::PIX_BITS-1:0];
         dcsp_pkg::CSR_IMAGE_HEIGHT:  cur_height     = data[dcsp_pkg::PIX_BITS-1:0];
         default: ;
      endcase
   endfunction

   // expected pixels for one accepted word, queued in order
   function automatic void plot_segment(bit restart);
      int unsigned                   ord;
      logic [dcsp_pkg::IDX_BITS:0]   total;
      int                            j;
      longint                        dx;
      longint                        dy;
      longint                        px;
      longint                        py;
      bit                            on_img;
      plot_word_type                 w;
      if (restart) load_pen();
      ord   = (cur_order > dcsp_pkg::MAX_ORDER) ? dcsp_pkg::MAX_ORDER : cur_order;
      total = (dcsp_pkg::IDX_BITS + 1)'(1) << ord;
      if ({1'b0, seg_idx} >= total) begin
         w = '{x: '0, y: '0, on_img: 1'b0, last: 1'b1, done: 1'b1};
         pending_plots.push_back(w);
         return;
      end
      // turn direction comes from the bit above the lowest set bit
      if (seg_idx != 0) begin
         j = 0;
         while (seg_idx[j] == 1'b0) j++;
         heading = seg_idx[j+1] ? heading + 2'd1 : heading + 2'd3;
      end
      dx = 0;
      dy = 0;
      case (heading)
         dcsp_pkg::HEAD_UP:    dy = 1;
         dcsp_pkg::HEAD_RIGHT: dx = -1;
         dcsp_pkg::HEAD_DOWN:  dy = -1;
         default:              dx = 1;
      endcase
      for (int t = 0; t < dcsp_pkg::SEGMENT_PIXELS; t++) begin
         px = sat_coord(longint'(pen_x) + dx * t);
         py = sat_coord(longint'(pen_y) + dy * t);
         on_img = px > 0 && py > 0 && px < longint'(cur_width)
               && py < longint'(cur_height);
         w.x      = on_img ? px[dcsp_pkg::PIX_BITS-1:0] : '0;
         w.y      = on_img ? py[dcsp_pkg::PIX_BITS-1:0] : '0;
         w.on_img = on_img;
         w.last   = (t == dcsp_pkg::SEGMENT_PIXELS - 1);
         w.done   = 1'b0;
         pending_plots.push_back(w);
      end
      pen_x   = dcsp_pkg::COORD_BITS'(sat_coord(longint'(pen_x)
                                                + dx * dcsp_pkg::SEGMENT_PIXELS));
      pen_y   = dcsp_pkg::COORD_BITS'(sat_coord(longint'(pen_y)
                                                + dy * dcsp_pkg::SEGMENT_PIXELS));
      seg_idx = seg_idx + dcsp_pkg::IDX_BITS'(1);
   endfunction

   function automatic void compare_field(string name,
                                         logic [dcsp_pkg::PIX_BITS-1:0] exp_v,
                                         logic [dcsp_pkg::PIX_BITS-1:0] got_v);
      if (got_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
         error_count++;
      end
   endfunction

   // result side: check every accepted word, then pick next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_plots.size() == 0) begin
               $display({"%0t: unexpected word, expected none, ",
                         "got x=%0d y=%0d on=%0b last=%0b done=%0b"},
                        $time, rsp_pixel_x, rsp_pixel_y, rsp_on_image, rsp_last,
                        rsp_done_res);
               error_count++;
            end else begin
               want = pending_plots.pop_front();
               compare_field("pixel_x", want.x, rsp_pixel_x);
               compare_field("pixel_y", want.y, rsp_pixel_y);
               compare_field("on_image", dcsp_pkg::PIX_BITS'(want.on_img),
                             dcsp_pkg::PIX_BITS'(rsp_on_image));
               compare_field("last", dcsp_pkg::PIX_BITS'(want.last),
                             dcsp_pkg::PIX_BITS'(rsp_last));
               compare_field("done_res", dcsp_pkg::PIX_BITS'(want.done),
                             dcsp_pkg::PIX_BITS'(rsp_done_res));
            end
         end
         // long hold-off so the command queue fills and backs up the input
         if (hold_tag != seen_tag) begin
            seen_tag  = hold_tag;
            hold_left = $urandom_range(250, 150);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_word(bit restart, bit typed, plot_word_type typed_word);
      int base;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      base = pending_plots.size();
      plot_segment(restart);
      if (typed) pending_plots[base] = typed_word;
   endtask

   // stop sending and wait for every expected word, with a bound
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_plots.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [dcsp_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [dcsp_pkg::CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      set_reg(idx, data);
   endtask

   task automatic program_regs(logic [dcsp_pkg::ORDER_BITS-1:0] ord,
                               logic [dcsp_pkg::HEAD_BITS-1:0] head,
                               logic [dcsp_pkg::PIX_BITS-1:0] sx,
                               logic [dcsp_pkg::PIX_BITS-1:0] sy,
                               logic [dcsp_pkg::PIX_BITS-1:0] w,
                               logic [dcsp_pkg::PIX_BITS-1:0] h);
      settle();
      // junk in the unused upper bits must be masked off
      write_reg(dcsp_pkg::CSR_CURVE_ORDER, {7'($urandom), ord});
      write_reg(dcsp_pkg::CSR_START_HEADING, {10'($urandom), head});
      write_reg(dcsp_pkg::CSR_START_X, sx);
      write_reg(dcsp_pkg::CSR_START_Y, sy);
      write_reg(dcsp_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(dcsp_pkg::CSR_IMAGE_HEIGHT, h);
      csr_wr_en <= 1'b0;
   endtask

   function automatic void add_csr(logic [dcsp_pkg::CSR_IDX_BITS-1:0] idx,
                                   logic [dcsp_pkg::CSR_DATA_BITS-1:0] data);
      step_type s;
      s = '{is_csr: 1'b1, idx: idx, data: data, restart: 1'b0, typed: 1'b0, word: '0};
      directed.push_back(s);
   endfunction

   function automatic void add_word(bit restart);
      step_type s;
      s = '{is_csr: 1'b0, idx: '0, data: '0, restart: restart, typed: 1'b0, word: '0};
      directed.push_back(s);
   endfunction

   function automatic void add_typed(bit restart, int x, int y, bit on_img, bit last,
                                     bit done);
      step_type s;
      s = '{is_csr: 1'b0, idx: '0, data: '0, restart: restart, typed: 1'b1,
            word: '{x: dcsp_pkg::PIX_BITS'(x), y: dcsp_pkg::PIX_BITS'(y),
                    on_img: on_img, last: last, done: done}};
      directed.push_back(s);
   endfunction

   function automatic logic [dcsp_pkg::ORDER_BITS-1:0] pick_order();
      case ($urandom_range(7))
         0:       return '0;
         1:       return 5'd31;
         2:       return 5'(dcsp_pkg::MAX_ORDER);
         3:       return 5'($urandom_range(31, dcsp_pkg::MAX_ORDER + 1));
         default: return 5'($urandom_range(4, 1));
      endcase
   endfunction

   function automatic logic [dcsp_pkg::PIX_BITS-1:0] pick_coord();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return 12'd1;
         3:       return 12'($urandom);
         default: return 12'($urandom_range(2000, 100));
      endcase
   endfunction

   function automatic logic [dcsp_pkg::PIX_BITS-1:0] pick_extent();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 12'd1;
         2:       return '1;
         default: return 12'($urandom_range(4095, 1000));
      endcase
   endfunction

   initial begin
      bit restart;
      bit csr_open;
      int n;
      // predictor starts from the register defaults
      cur_order      = dcsp_pkg::RST_CURVE_ORDER;
      cur_start_head = dcsp_pkg::RST_START_HEADING;
      cur_start_x    = dcsp_pkg::RST_START_X;
      cur_start_y    = dcsp_pkg::RST_START_Y;
      cur_width      = dcsp_pkg::RST_IMAGE_WIDTH;
      cur_height     = dcsp_pkg::RST_IMAGE_HEIGHT;
      load_pen();

      // directed table
      add_typed(0, 960, 540, 1, 0, 0);          // first segment after reset, no turn
      add_word(0);
      add_word(0);
      add_typed(1, 960, 540, 1, 0, 0);          // restart mid-curve
      add_csr(dcsp_pkg::CSR_CURVE_ORDER, 12'd0);          // one-segment curve
      add_typed(1, 960, 540, 1, 0, 0);
      add_typed(0, 0, 0, 0, 1, 1);              // curve finished
      add_csr(dcsp_pkg::CSR_CURVE_ORDER, 12'd31);         // order above max is clamped
      add_csr(dcsp_pkg::CSR_START_HEADING,
              dcsp_pkg::CSR_DATA_BITS'(dcsp_pkg::HEAD_LEFT));
      add_csr(dcsp_pkg::CSR_START_X, 12'd0);
      add_csr(dcsp_pkg::CSR_START_Y, 12'd4095);
      add_csr(dcsp_pkg::CSR_IMAGE_WIDTH, 12'd4095);
      add_csr(dcsp_pkg::CSR_IMAGE_HEIGHT, 12'd4095);
      add_typed(1, 0, 0, 0, 0, 0);              // column zero is off the image
      add_word(0);
      add_word(0);
      add_csr(dcsp_pkg::CSR_CURVE_ORDER, 12'd1);
      add_csr(dcsp_pkg::CSR_START_HEADING,
              dcsp_pkg::CSR_DATA_BITS'(dcsp_pkg::HEAD_DOWN));
      add_csr(dcsp_pkg::CSR_START_X, 12'd1);
      add_csr(dcsp_pkg::CSR_START_Y, 12'd1);
      add_csr(dcsp_pkg::CSR_IMAGE_WIDTH, 12'd1);
      add_csr(dcsp_pkg::CSR_IMAGE_HEIGHT, 12'd1);
      add_typed(1, 0, 0, 0, 0, 0);              // smallest image holds no pixel
      add_csr(dcsp_pkg::CSR_IMAGE_WIDTH, 12'd4095);
      add_csr(dcsp_pkg::CSR_IMAGE_HEIGHT, 12'd4095);
      add_csr(dcsp_pkg::CSR_START_X, 12'd4094);
      add_csr(dcsp_pkg::CSR_START_Y, 12'd4094);
      add_typed(1, 4094, 4094, 1, 0, 0);        // last pixel inside the largest image
      add_word(0);
      add_typed(0, 0, 0, 0, 1, 1);
      add_typed(0, 0, 0, 0, 1, 1);              // finished stays finished
      add_typed(1, 4094, 4094, 1, 0, 0);        // restart after finish
      add_csr(CSR_SPARE_LO, 12'hFFF);           // writes past the map are dropped
      add_csr(CSR_SPARE_HI, 12'h000);
      add_typed(1, 4094, 4094, 1, 0, 0);
      add_csr(dcsp_pkg::CSR_CURVE_ORDER, 12'd3);
      add_csr(dcsp_pkg::CSR_START_HEADING,
              dcsp_pkg::CSR_DATA_BITS'(dcsp_pkg::HEAD_RIGHT));
      add_csr(dcsp_pkg::CSR_IMAGE_WIDTH, 12'd1920);
      add_csr(dcsp_pkg::CSR_IMAGE_HEIGHT, 12'd1080);
      add_csr(dcsp_pkg::CSR_START_X, 12'd2000);
      add_csr(dcsp_pkg::CSR_START_Y, 12'd500);
      add_typed(1, 0, 0, 0, 0, 0);              // start past the right edge
      add_word(0);
      add_word(0);
      add_word(0);
      add_csr(dcsp_pkg::CSR_START_X, 12'd100);            // must not move the running pen
      add_word(0);
      add_word(0);
      add_word(0);
      add_word(0);
      add_typed(0, 0, 0, 0, 1, 1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      csr_open = 1'b0;
      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            if (!csr_open) begin
               settle();
               csr_open = 1'b1;
            end
            write_reg(directed[i].idx, directed[i].data);
         end else begin
            if (csr_open) begin
               csr_wr_en <= 1'b0;
               csr_open = 1'b0;
            end
            send_word(directed[i].restart, directed[i].typed, directed[i].word);
         end
      end

      // random phases, each with its own register set and idling mix
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         if (phase == 6) begin
            // one long run from a central start to reach deep turn patterns
            program_regs(5'(dcsp_pkg::MAX_ORDER), 2'($urandom), 12'd960, 12'd540,
                         12'd1920, 12'd1080);
            n = 80;
         end else begin
            program_regs(pick_order(), 2'($urandom), pick_coord(), pick_coord(),
                         pick_extent(), pick_extent());
            n = 36;
         end
         for (int k = 0; k < n; k++) begin
            restart = (k == 0) || (phase != 6 && $urandom_range(99) < 6);
            if (phase == 2 && k == 10) hold_tag++;
            if (phase == 5 && k == 18) settle();
            send_word(restart, 1'b0, '0);
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (pending_plots.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, pending_plots.size());
         error_count += pending_plots.size();
      end
      if (error_count == 0) begin
         $display("dragon_curve_segment_plotter_top_tb: clean");
      end else begin
         $display("dragon_curve_segment_plotter_top_tb: errors");
      end
      $finish;
   end

endmodule

>>> files.f
sv/dcsp_pkg.sv
sv/dcsp_front.sv
sv/dcsp_queue.sv
sv/dcsp_back.sv
sv/dragon_curve_segment_plotter_top.sv
tb/dragon_curve_segment_plotter_top_tb.sv
